// File: rtl/core/sbcp_pkg.sv
// Shared constants and register codes for the segment box crossing points unit.
`default_nettype none
package sbcp_pkg;

   // Default coordinate format: signed Q16.16.
   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   // Four candidates per segment, one per box side: left, right, bottom, top.
   localparam int NUM_CAND = 4;

   // Configuration register indexes, in address order.
   typedef enum logic [1:0] {
      REG_CLIP_X_MIN = 2'd0,
      REG_CLIP_X_MAX = 2'd1,
      REG_CLIP_Y_MIN = 2'd2,
      REG_CLIP_Y_MAX = 2'd3
   } csr_reg_type;

endpackage
`default_nettype wire

// File: rtl/core/sbcp_csr.sv
// Clip box registers behind an APB-style write and read port.
`default_nettype none
module sbcp_csr #(
   parameter int COORD_WIDTH = sbcp_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = sbcp_pkg::FRAC_BITS_DEF,
   localparam int CsrDw = (COORD_WIDTH > 32) ? 64 : 32,
   localparam int CsrAw = (COORD_WIDTH > 32) ? 5 : 4
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           psel,
   input  wire                           penable,
   input  wire                           pwrite,
   input  wire        [CsrAw-1:0]        paddr,
   input  wire        [CsrDw-1:0]        pwdata,
   output logic       [CsrDw-1:0]        prdata,
   output logic                          pready,
   output logic signed [COORD_WIDTH-1:0] clip_x_min,
   output logic signed [COORD_WIDTH-1:0] clip_x_max,
   output logic signed [COORD_WIDTH-1:0] clip_y_min,
   output logic signed [COORD_WIDTH-1:0] clip_y_max
);
   import sbcp_pkg::*;

   localparam logic [COORD_WIDTH-1:0] One =
      {{(COORD_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS;

   logic [COORD_WIDTH-1:0] x_min_ff, x_max_ff, y_min_ff, y_max_ff;
   csr_reg_type            sel;
   logic                   wr;

   assign sel    = csr_reg_type'(paddr[CsrAw-1:CsrAw-2]);
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff <= '0;
         x_max_ff <= One;
         y_min_ff <= '0;
         y_max_ff <= One;
      end else if (wr) begin
         case (sel)
            REG_CLIP_X_MIN: x_min_ff <= pwdata[COORD_WIDTH-1:0];
            REG_CLIP_X_MAX: x_max_ff <= pwdata[COORD_WIDTH-1:0];
            REG_CLIP_Y_MIN: y_min_ff <= pwdata[COORD_WIDTH-1:0];
            REG_CLIP_Y_MAX: y_max_ff <= pwdata[COORD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (sel)
         REG_CLIP_X_MIN: prdata[COORD_WIDTH-1:0] = x_min_ff;
         REG_CLIP_X_MAX: prdata[COORD_WIDTH-1:0] = x_max_ff;
         REG_CLIP_Y_MIN: prdata[COORD_WIDTH-1:0] = y_min_ff;
         REG_CLIP_Y_MAX: prdata[COORD_WIDTH-1:0] = y_max_ff;
         default:        prdata = '0;
      endcase
   end

   assign clip_x_min = x_min_ff;
   assign clip_x_max = x_max_ff;
   assign clip_y_min = y_min_ff;
   assign clip_y_max = y_max_ff;

endmodule
`default_nettype wire

// File: rtl/core/sbcp_delay.sv
// Delay line with valid bits that matches the divider latency for side data.
`default_nettype none
module sbcp_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              en,
   input  wire              in_valid,
   input  wire  [WIDTH-1:0] in_data,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data
);
   logic             v_ff [DEPTH];
   logic [WIDTH-1:0] d_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) v_ff[i] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int i = 1; i < DEPTH; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff[0] <= in_data;
         for (int i = 1; i < DEPTH; i++) d_ff[i] <= d_ff[i-1];
      end
   end

   assign out_valid = v_ff[DEPTH-1];
   assign out_data  = d_ff[DEPTH-1];

endmodule
`default_nettype wire

// File: rtl/core/sbcp_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating at 2^W.
`default_nettype none
module sbcp_div #(
   parameter int W = sbcp_pkg::COORD_WIDTH_DEF
) (
   input  wire            clock,
   input  wire            en,
   input  wire  [2*W+1:0] num,
   input  wire  [W:0]     den,
   output logic [W:0]     quo
);
   localparam int Pw = 2*W + 2;

   logic [W:0]   rem_ff [W+1];
   logic [W-1:0] low_ff [W+1];
   logic [W-1:0] q_ff   [W+1];
   logic [W:0]   den_ff [W+1];
   logic         ovf_ff [W+1];

   // A quotient of 2^W or more lands outside any box, so it saturates there.
   always_ff @(posedge clock) begin
      if (en) begin
         ovf_ff[0] <= num[Pw-1:W] >= {1'b0, den};
         rem_ff[0] <= num[Pw-2:W];
         low_ff[0] <= num[W-1:0];
         q_ff[0]   <= '0;
         den_ff[0] <= den;
      end
   end

   for (genvar k = 1; k <= W; k++) begin : g_stage
      logic [W+1:0] trial;
      logic [W+1:0] diff;
      logic         ge;
      assign trial = {rem_ff[k-1], low_ff[k-1][W-1]};
      assign diff  = trial - {1'b0, den_ff[k-1]};
      assign ge    = trial >= {1'b0, den_ff[k-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? diff[W:0] : trial[W:0];
            low_ff[k] <= {low_ff[k-1][W-2:0], 1'b0};
            q_ff[k]   <= {q_ff[k-1][W-2:0], ge};
            den_ff[k] <= den_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign quo = ovf_ff[W] ? {1'b1, {W{1'b0}}} : {1'b0, q_ff[W]};

endmodule
`default_nettype wire

// File: rtl/core/sbcp_sort.sv
// Two-stage stable sort of up to four kept points by x, then slot placement.
`default_nettype none
module sbcp_sort #(
   parameter int W = sbcp_pkg::COORD_WIDTH_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  en,
   input  wire                  in_valid,
   input  wire  [sbcp_pkg::NUM_CAND-1:0] in_keep,
   input  wire  signed [W-1:0]  in_x [sbcp_pkg::NUM_CAND],
   input  wire  signed [W-1:0]  in_y [sbcp_pkg::NUM_CAND],
   input  wire                  in_dir_pos,
   input  wire                  in_nosort,
   output logic                 out_valid,
   output logic signed [W-1:0]  out_x [sbcp_pkg::NUM_CAND],
   output logic signed [W-1:0]  out_y [sbcp_pkg::NUM_CAND],
   output logic [2:0]           out_cnt
);
   import sbcp_pkg::*;

   logic                a_v_ff;
   logic [NUM_CAND-1:0] a_keep_ff;
   logic signed [W-1:0] a_x_ff [NUM_CAND];
   logic signed [W-1:0] a_y_ff [NUM_CAND];
   // prec[i][j]: point i goes strictly ahead of point j.
   logic [NUM_CAND-1:0] prec_in [NUM_CAND];
   logic [NUM_CAND-1:0] prec_ff [NUM_CAND];

   logic                b_v_ff;
   logic signed [W-1:0] b_x_ff [NUM_CAND];
   logic signed [W-1:0] b_y_ff [NUM_CAND];
   logic [2:0]          b_cnt_ff;

   logic [2:0]          rank [NUM_CAND];
   logic signed [W-1:0] slot_x [NUM_CAND];
   logic signed [W-1:0] slot_y [NUM_CAND];
   logic [2:0]          cnt;

   always_comb begin
      for (int i = 0; i < NUM_CAND; i++) begin
         for (int j = 0; j < NUM_CAND; j++) begin
            prec_in[i][j] = !in_nosort &&
               (in_dir_pos ? (in_x[i] < in_x[j]) : (in_x[i] > in_x[j]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= in_valid;
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_keep_ff <= in_keep;
         a_x_ff    <= in_x;
         a_y_ff    <= in_y;
         prec_ff   <= prec_in;
         b_x_ff    <= slot_x;
         b_y_ff    <= slot_y;
         b_cnt_ff  <= cnt;
      end
   end

   // Equal x keeps candidate order, which makes the sort stable.
   always_comb begin
      cnt = '0;
      for (int i = 0; i < NUM_CAND; i++) begin
         rank[i] = '0;
         cnt = cnt + {2'b00, a_keep_ff[i]};
         for (int j = 0; j < NUM_CAND; j++) begin
            if (j < i && a_keep_ff[j] && !prec_ff[i][j]) rank[i] = rank[i] + 3'd1;
            if (j > i && a_keep_ff[j] && prec_ff[j][i])  rank[i] = rank[i] + 3'd1;
         end
      end
      for (int r = 0; r < NUM_CAND; r++) begin
         slot_x[r] = '0;
         slot_y[r] = '0;
         for (int i = 0; i < NUM_CAND; i++) begin
            if (a_keep_ff[i] && rank[i][1:0] == 2'(r)) begin
               slot_x[r] = slot_x[r] | a_x_ff[i];
               slot_y[r] = slot_y[r] | a_y_ff[i];
            end
         end
      end
   end

   assign out_valid = b_v_ff;
   assign out_x     = b_x_ff;
   assign out_y     = b_y_ff;
   assign out_cnt   = b_cnt_ff;

endmodule
`default_nettype wire

// File: rtl/core/segment_box_crossing_points_unit.sv
// Top level of the segment box crossing points unit: pipeline, packet stage, ports.
//
//   Channel   Direction  Handshake            Payload
//   req       in         req_valid/req_ready  start_x, start_y, end_x, end_y
//   rsp       out        rsp_valid/rsp_ready  cross_x, cross_y, found, last
//   csr       in/out     psel/penable/pready  paddr, pwdata, prdata (clip box)
//
// One segment enters per cycle while req_ready is high. On its way out it passes the
// input register, differences, multipliers, the bit-per-stage dividers (COORD_WIDTH + 1
// stages), box test, sort and packet stage, which gives one to four result items per
// segment. Reset is synchronous, clears all valid bits and resets the clip box to 0..1.0.
// The pipeline advances whenever its tail is empty or the packet stage frees up,
// so a stalled output still lets bubbles fill; nothing is dropped or repeated.
`default_nettype none
module segment_box_crossing_points_unit #(
   parameter int COORD_WIDTH = sbcp_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = sbcp_pkg::FRAC_BITS_DEF,
   localparam int CsrDw = (COORD_WIDTH > 32) ? 64 : 32,
   localparam int CsrAw = (COORD_WIDTH > 32) ? 5 : 4
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire  signed [COORD_WIDTH-1:0] req_start_x,
   input  wire  signed [COORD_WIDTH-1:0] req_start_y,
   input  wire  signed [COORD_WIDTH-1:0] req_end_x,
   input  wire  signed [COORD_WIDTH-1:0] req_end_y,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_cross_x,
   output logic signed [COORD_WIDTH-1:0] rsp_cross_y,
   output logic                          rsp_found,
   output logic                          rsp_last,
   input  wire                           psel,
   input  wire                           penable,
   input  wire                           pwrite,
   input  wire         [CsrAw-1:0]       paddr,
   input  wire         [CsrDw-1:0]       pwdata,
   output logic        [CsrDw-1:0]       prdata,
   output logic                          pready
);
   import sbcp_pkg::*;

   localparam int W      = COORD_WIDTH;
   localparam int Dw     = W + 1;       // differences and magnitudes
   localparam int Pw     = 2*W + 2;     // products
   localparam int Xw     = W + 2;       // candidate coordinates before the box test
   localparam int DivLat = W + 1;
   localparam int SideW  = NUM_CAND + 4*W + 4;

   // Clip box.
   logic signed [W-1:0] xl, xh, yl, yh;

   sbcp_csr #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
      .clip_x_min(xl), .clip_x_max(xh), .clip_y_min(yl), .clip_y_max(yh)
   );

   // Global advance. All stages move together; the packet stage decides.
   logic en;
   logic sort_v;
   logic pkt_v_ff;
   logic pkt_finish;

   assign en        = !sort_v || !pkt_v_ff || pkt_finish;
   assign req_ready = en;

   // Stage 1: input register.
   logic                s1_v_ff;
   logic signed [W-1:0] s1_x0_ff, s1_y0_ff, s1_x1_ff, s1_y1_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (en) s1_v_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_x0_ff <= req_start_x;
         s1_y0_ff <= req_start_y;
         s1_x1_ff <= req_end_x;
         s1_y1_ff <= req_end_y;
      end
   end

   // Stage 2: differences, magnitudes and signs. Candidates 0 and 1 solve for y
   // at the left and right edges, candidates 2 and 3 solve for x at the bottom
   // and top edges.
   logic signed [Dw-1:0] dx, dy;
   logic signed [Dw-1:0] tdiff [NUM_CAND];
   logic        [Dw-1:0] am_in [NUM_CAND];
   logic        [Dw-1:0] bm_in [NUM_CAND];
   logic        [Dw-1:0] dxm, dym;
   logic [NUM_CAND-1:0]  neg_in;
   logic                 vert_ok, horz_ok;

   assign dx = Dw'(s1_x1_ff) - Dw'(s1_x0_ff);
   assign dy = Dw'(s1_y1_ff) - Dw'(s1_y0_ff);
   assign dxm = dx[Dw-1] ? Dw'(-dx) : Dw'(dx);
   assign dym = dy[Dw-1] ? Dw'(-dy) : Dw'(dy);

   always_comb begin
      tdiff[0] = Dw'(xl) - Dw'(s1_x0_ff);
      tdiff[1] = Dw'(xh) - Dw'(s1_x0_ff);
      tdiff[2] = Dw'(yl) - Dw'(s1_y0_ff);
      tdiff[3] = Dw'(yh) - Dw'(s1_y0_ff);
      for (int k = 0; k < NUM_CAND; k++) begin
         am_in[k]  = (k < 2) ? dym : dxm;
         bm_in[k]  = tdiff[k][Dw-1] ? Dw'(-tdiff[k]) : Dw'(tdiff[k]);
         neg_in[k] = dx[Dw-1] ^ dy[Dw-1] ^ tdiff[k][Dw-1];
      end
   end

   // An axis-parallel segment counts only when it crosses the whole box.
   assign vert_ok = s1_x1_ff > xl && s1_x1_ff < xh &&
                    ((s1_y1_ff > yh && s1_y0_ff < yl) || (s1_y1_ff < yl && s1_y0_ff > yh));
   assign horz_ok = s1_y1_ff > yl && s1_y1_ff < yh &&
                    ((s1_x1_ff > xh && s1_x0_ff < xl) || (s1_x1_ff < xl && s1_x0_ff > xh));

   logic                 s2_v_ff;
   logic        [Dw-1:0] s2_am_ff [NUM_CAND];
   logic        [Dw-1:0] s2_bm_ff [NUM_CAND];
   logic        [Dw-1:0] s2_dxm_ff, s2_dym_ff;
   logic [SideW-1:0]     s2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else if (en) s2_v_ff <= s1_v_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_am_ff   <= am_in;
         s2_bm_ff   <= bm_in;
         s2_dxm_ff  <= dxm;
         s2_dym_ff  <= dym;
         s2_side_ff <= {neg_in, s1_x0_ff, s1_y0_ff, s1_x1_ff, s1_y1_ff,
                        (dx > 0), (dx == 0 || dy == 0),
                        ((dx == 0) ? vert_ok : horz_ok), (dx == 0)};
      end
   end

   // Stage 3: one multiplier per candidate.
   logic             s3_v_ff;
   logic [Pw-1:0]    s3_prod_ff [NUM_CAND];
   logic [Dw-1:0]    s3_den_ff  [NUM_CAND];
   logic [SideW-1:0] s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) s3_v_ff <= 1'b0;
      else if (en) s3_v_ff <= s2_v_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NUM_CAND; k++) begin
            s3_prod_ff[k] <= Pw'(s2_am_ff[k]) * Pw'(s2_bm_ff[k]);
            s3_den_ff[k]  <= (k < 2) ? s2_dxm_ff : s2_dym_ff;
         end
         s3_side_ff <= s2_side_ff;
      end
   end

   // Dividers, with the side data delayed alongside.
   logic [Dw-1:0]    quo [NUM_CAND];
   logic             dv_v;
   logic [SideW-1:0] dv_side;

   for (genvar k = 0; k < NUM_CAND; k++) begin : g_div
      sbcp_div #(.W(W)) u_div (
         .clock, .en, .num(s3_prod_ff[k]), .den(s3_den_ff[k]), .quo(quo[k])
      );
   end

   sbcp_delay #(.WIDTH(SideW), .DEPTH(DivLat)) u_side (
      .clock, .reset, .en, .in_valid(s3_v_ff), .in_data(s3_side_ff),
      .out_valid(dv_v), .out_data(dv_side)
   );

   logic [NUM_CAND-1:0] d_neg;
   logic signed [W-1:0] d_x0, d_y0, d_x1, d_y1;
   logic                d_dir_pos, d_spec, d_spec_ok, d_vert;

   assign {d_neg, d_x0, d_y0, d_x1, d_y1, d_dir_pos, d_spec, d_spec_ok, d_vert} = dv_side;

   // Stage 4: add the quotient back and test against segment bounds and box.
   logic signed [Xw-1:0] cx [NUM_CAND];
   logic signed [Xw-1:0] cy [NUM_CAND];
   logic signed [Xw-1:0] bxl, bxh, byl, byh, exl, exh, eyl, eyh, b0;
   logic [NUM_CAND-1:0]  keep_in;
   logic signed [W-1:0]  kx_in [NUM_CAND];
   logic signed [W-1:0]  ky_in [NUM_CAND];

   always_comb begin
      exl = Xw'(xl);
      exh = Xw'(xh);
      eyl = Xw'(yl);
      eyh = Xw'(yh);
      bxl = (d_x0 < d_x1) ? Xw'(d_x0) : Xw'(d_x1);
      bxh = (d_x0 < d_x1) ? Xw'(d_x1) : Xw'(d_x0);
      byl = (d_y0 < d_y1) ? Xw'(d_y0) : Xw'(d_y1);
      byh = (d_y0 < d_y1) ? Xw'(d_y1) : Xw'(d_y0);
      b0  = '0;
      for (int k = 0; k < NUM_CAND; k++) begin
         b0 = (k < 2) ? Xw'(d_y0) : Xw'(d_x0);
         if (k < 2) begin
            cx[k] = (k == 0) ? exl : exh;
            cy[k] = d_neg[k] ? b0 - Xw'(quo[k]) : b0 + Xw'(quo[k]);
         end else begin
            cy[k] = (k == 2) ? eyl : eyh;
            cx[k] = d_neg[k] ? b0 - Xw'(quo[k]) : b0 + Xw'(quo[k]);
         end
         keep_in[k] = cx[k] >= bxl && cx[k] <= bxh && cy[k] >= byl && cy[k] <= byh &&
                      cx[k] >= exl && cx[k] <= exh && cy[k] >= eyl && cy[k] <= eyh;
         kx_in[k] = cx[k][W-1:0];
         ky_in[k] = cy[k][W-1:0];
      end
      // Axis-parallel segments replace the candidates with the two box edge points.
      if (d_spec) begin
         keep_in  = {2'b00, d_spec_ok, d_spec_ok};
         kx_in[0] = d_vert ? d_x1 : xl;
         ky_in[0] = d_vert ? yl : d_y1;
         kx_in[1] = d_vert ? d_x1 : xh;
         ky_in[1] = d_vert ? yh : d_y1;
      end
   end

   logic                s4_v_ff;
   logic [NUM_CAND-1:0] s4_keep_ff;
   logic signed [W-1:0] s4_x_ff [NUM_CAND];
   logic signed [W-1:0] s4_y_ff [NUM_CAND];
   logic                s4_dir_pos_ff, s4_nosort_ff;

   always_ff @(posedge clock) begin
      if (reset) s4_v_ff <= 1'b0;
      else if (en) s4_v_ff <= dv_v;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_keep_ff    <= keep_in;
         s4_x_ff       <= kx_in;
         s4_y_ff       <= ky_in;
         s4_dir_pos_ff <= d_dir_pos;
         s4_nosort_ff  <= d_spec;
      end
   end

   // Stages 5 and 6: sort.
   logic signed [W-1:0] sort_x [NUM_CAND];
   logic signed [W-1:0] sort_y [NUM_CAND];
   logic [2:0]          sort_cnt;

   sbcp_sort #(.W(W)) u_sort (
      .clock, .reset, .en,
      .in_valid(s4_v_ff), .in_keep(s4_keep_ff), .in_x(s4_x_ff), .in_y(s4_y_ff),
      .in_dir_pos(s4_dir_pos_ff), .in_nosort(s4_nosort_ff),
      .out_valid(sort_v), .out_x(sort_x), .out_y(sort_y), .out_cnt(sort_cnt)
   );

   // Packet stage: holds one segment's results, handing one out per cycle with rsp_ready.
   // A count of zero sends a single item with found low.
   logic signed [W-1:0] pkt_x_ff [NUM_CAND];
   logic signed [W-1:0] pkt_y_ff [NUM_CAND];
   logic [2:0]          pkt_cnt_ff;
   logic [1:0]          pkt_idx_ff;
   logic                pkt_load;
   logic                rsp_take;

   assign rsp_valid   = pkt_v_ff;
   assign rsp_found   = pkt_cnt_ff != 3'd0;
   assign rsp_last    = !rsp_found || ({1'b0, pkt_idx_ff} == pkt_cnt_ff - 3'd1);
   assign rsp_cross_x = rsp_found ? pkt_x_ff[pkt_idx_ff] : '0;
   assign rsp_cross_y = rsp_found ? pkt_y_ff[pkt_idx_ff] : '0;
   assign rsp_take    = rsp_valid && rsp_ready;
   assign pkt_finish  = rsp_take && rsp_last;
   assign pkt_load    = en && sort_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_v_ff   <= 1'b0;
         pkt_idx_ff <= '0;
      end else if (pkt_load) begin
         pkt_v_ff   <= 1'b1;
         pkt_idx_ff <= '0;
      end else if (pkt_finish) begin
         pkt_v_ff   <= 1'b0;
      end else if (rsp_take) begin
         pkt_idx_ff <= pkt_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (pkt_load) begin
         pkt_x_ff   <= sort_x;
         pkt_y_ff   <= sort_y;
         pkt_cnt_ff <= sort_cnt;
      end
   end

   // The input side stalls only while a full packet waits with more behind it.
   a_stall_only_on_full_packet: assert property (
      @(posedge clock) disable iff (reset) !req_ready |-> (rsp_valid && sort_v)
   ) else $error("input stalled without a waiting packet");

   a_empty_is_single: assert property (
      @(posedge clock) disable iff (reset) (rsp_valid && !rsp_found) |-> rsp_last
   ) else $error("empty result is not the last item");

   a_more_follow: assert property (
      @(posedge clock) disable iff (reset) (rsp_take && !rsp_last) |=> rsp_valid
   ) else $error("packet dropped before its last item");

   a_index_in_range: assert property (
      @(posedge clock) disable iff (reset)
         rsp_valid |-> (pkt_cnt_ff == 3'd0 || {1'b0, pkt_idx_ff} < pkt_cnt_ff)
   ) else $error("packet index beyond its count");

   a_count_bound: assert property (
      @(posedge clock) disable iff (reset) rsp_valid |-> pkt_cnt_ff <= 3'd4
   ) else $error("packet count above four");

endmodule
`default_nettype wire

// File: tb/segment_box_crossing_points_checker.sv
// Checker for the segment box crossing points unit: predicts crossing items and compares them.
`default_nettype none
module segment_box_crossing_points_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   input  wire         req_ready,
   input  wire  [31:0] req_start_x,
   input  wire  [31:0] req_start_y,
   input  wire  [31:0] req_end_x,
   input  wire  [31:0] req_end_y,
   input  wire         rsp_valid,
   input  wire         rsp_ready,
   input  wire  [31:0] rsp_cross_x,
   input  wire  [31:0] rsp_cross_y,
   input  wire         rsp_found,
   input  wire         rsp_last,
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire  [3:0]  paddr,
   input  wire  [31:0] pwdata,
   input  wire         pready,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import sbcp_pkg::*;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic        found;
      logic        last;
   } crossing_type;

   crossing_type crossings_due[$];
   logic [31:0] box_x_min, box_x_max, box_y_min, box_y_max;

   function automatic logic [127:0] magnitude(longint v);
      return (v < 0) ? 128'(-v) : 128'(v);
   endfunction

   // b0 + trunc(db * (target - a0) / da), quotient saturated at 2^60.
   function automatic longint edge_hit(longint a0, longint da, longint b0, longint db,
                                       longint target);
      longint       t;
      bit           neg;
      logic [127:0] q;
      t   = target - a0;
      neg = ((db < 0) != (t < 0)) != (da < 0);
      q   = (magnitude(db) * magnitude(t)) / magnitude(da);
      if (q > (128'd1 << 60)) q = 128'd1 << 60;
      return neg ? b0 - longint'(q[63:0]) : b0 + longint'(q[63:0]);
   endfunction

   task automatic predict_crossings(logic [31:0] sx, logic [31:0] sy,
                                    logic [31:0] ex, logic [31:0] ey);
      longint x0, y0, x1, y1, xl, xh, yl, yh, dx, dy, tx, ty;
      longint bxl, bxh, byl, byh;
      longint cx[4], cy[4], px[4], py[4];
      int     n, j;
      crossing_type c;
      x0 = longint'(signed'(sx)); y0 = longint'(signed'(sy));
      x1 = longint'(signed'(ex)); y1 = longint'(signed'(ey));
      xl = longint'(signed'(box_x_min)); xh = longint'(signed'(box_x_max));
      yl = longint'(signed'(box_y_min)); yh = longint'(signed'(box_y_max));
      dx = x1 - x0;
      dy = y1 - y0;
      n  = 0;
      if (dx == 0) begin
         if (x1 > xl && x1 < xh && ((y1 > yh && y0 < yl) || (y1 < yl && y0 > yh))) begin
            px[0] = x1; py[0] = yl;
            px[1] = x1; py[1] = yh;
            n = 2;
         end
      end else if (dy == 0) begin
         if (y1 > yl && y1 < yh && ((x1 > xh && x0 < xl) || (x1 < xl && x0 > xh))) begin
            px[0] = xl; py[0] = y1;
            px[1] = xh; py[1] = y1;
            n = 2;
         end
      end else begin
         bxl = (x0 < x1) ? x0 : x1; bxh = (x0 < x1) ? x1 : x0;
         byl = (y0 < y1) ? y0 : y1; byh = (y0 < y1) ? y1 : y0;
         cx[0] = xl; cy[0] = edge_hit(x0, dx, y0, dy, xl);
         cx[1] = xh; cy[1] = edge_hit(x0, dx, y0, dy, xh);
         cy[2] = yl; cx[2] = edge_hit(y0, dy, x0, dx, yl);
         cy[3] = yh; cx[3] = edge_hit(y0, dy, x0, dx, yh);
         for (int i = 0; i < 4; i++) begin
            if (cx[i] >= bxl && cx[i] <= bxh && cy[i] >= byl && cy[i] <= byh &&
                cx[i] >= xl && cx[i] <= xh && cy[i] >= yl && cy[i] <= yh) begin
               px[n] = cx[i]; py[n] = cy[i]; n++;
            end
         end
         // Stable insertion sort along the direction of travel.
         for (int i = 1; i < n; i++) begin
            tx = px[i]; ty = py[i]; j = i;
            while (j > 0 && ((dx > 0) ? (px[j-1] > tx) : (px[j-1] < tx))) begin
               px[j] = px[j-1]; py[j] = py[j-1]; j--;
            end
            px[j] = tx; py[j] = ty;
         end
      end
      if (n == 0) begin
         c = '{x: 32'd0, y: 32'd0, found: 1'b0, last: 1'b1};
         crossings_due = {crossings_due, c};
      end
      for (int i = 0; i < n; i++) begin
         c = '{x: px[i][31:0], y: py[i][31:0], found: 1'b1, last: (i == n - 1)};
         crossings_due = {crossings_due, c};
      end
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      crossing_type want;
      if (reset) begin
         box_x_min = 32'd0;
         box_x_max = 32'h0001_0000;
         box_y_min = 32'd0;
         box_y_max = 32'h0001_0000;
         crossings_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (crossings_due.size() == 0) begin
               report_mismatch("unexpected item", 32'({rsp_found, rsp_last}), 32'd0);
            end else begin
               want = crossings_due.pop_front();
               if (rsp_cross_x !== want.x) report_mismatch("cross_x", rsp_cross_x, want.x);
               if (rsp_cross_y !== want.y) report_mismatch("cross_y", rsp_cross_y, want.y);
               if (rsp_found !== want.found)
                  report_mismatch("found", 32'(rsp_found), 32'(want.found));
               if (rsp_last !== want.last)
                  report_mismatch("last", 32'(rsp_last), 32'(want.last));
            end
         end
         if (req_valid && req_ready)
            predict_crossings(req_start_x, req_start_y, req_end_x, req_end_y);
         if (psel && penable && pwrite && pready) begin
            case (csr_reg_type'(paddr[3:2]))
               REG_CLIP_X_MIN: box_x_min = pwdata;
               REG_CLIP_X_MAX: box_x_max = pwdata;
               REG_CLIP_Y_MIN: box_y_min = pwdata;
               REG_CLIP_Y_MAX: box_y_max = pwdata;
               default: ;
            endcase
         end
      end
      pending = crossings_due.size();
   end

endmodule
`default_nettype wire

// File: tb/segment_box_crossing_points_unit_tb.sv
// Testbench top for the segment box crossing points unit: stimulus, clip box setup and verdict.
`default_nettype none
module segment_box_crossing_points_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sbcp_pkg::*;

   // Settle time before a register write, covering the pipeline depth.
   localparam int DRAIN_CYCLES = 32 + 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   wire         req_ready;
   logic [31:0] req_start_x = '0, req_start_y = '0, req_end_x = '0, req_end_y = '0;
   wire         rsp_valid;
   logic        rsp_ready = 1'b0;
   wire  [31:0] rsp_cross_x, rsp_cross_y;
   wire         rsp_found, rsp_last;
   logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   wire  [31:0] prdata;
   wire         pready;
   int          fail_count, pending;

   // Idle style of the sender and receiver: when quiet is set, neither side
   // inserts gaps. A nonzero hold request makes the receiver stall that long.
   bit          quiet = 1'b0;
   int          hold_request = 0;
   // Clip box as last programmed, used to aim random segments at it.
   longint      bx_lo = 0, bx_hi = 65536, by_lo = 0, by_hi = 65536;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   segment_box_crossing_points_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_cross_x(rsp_cross_x), .rsp_cross_y(rsp_cross_y),
      .rsp_found(rsp_found), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   segment_box_crossing_points_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_cross_x(rsp_cross_x), .rsp_cross_y(rsp_cross_y),
      .rsp_found(rsp_found), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .fail_count(fail_count), .pending(pending)
   );

   // Gap length: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      if (quiet) return 0;
      if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
      return $urandom_range(8, 40);
   endfunction

   // The receiver changes ready only at falling edges. A hold request is
   // counted down here, cycle by cycle, while the sender keeps offering items.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            rsp_ready = 1'b0;
            hold_request--;
         end else if (quiet) begin
            rsp_ready = 1'b1;
         end else begin
            rsp_ready = ($urandom_range(0, 9) < 7);
         end
      end
   end

   // Offer one segment, called at a falling edge. The valid line is only
   // lowered when a gap comes before the item, so back-to-back items keep it high.
   task automatic send_segment(logic [31:0] sx, logic [31:0] sy,
                               logic [31:0] ex, logic [31:0] ey);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_start_x = sx;
      req_start_y = sy;
      req_end_x   = ex;
      req_end_y   = ey;
      req_valid   = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Register writes happen only once every expected item has arrived and the
   // pipeline has had time to empty.
   task automatic write_clip(csr_reg_type idx, logic [31:0] value);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic set_box(logic [31:0] xl, logic [31:0] xh,
                          logic [31:0] yl, logic [31:0] yh);
      write_clip(REG_CLIP_X_MIN, xl);
      write_clip(REG_CLIP_X_MAX, xh);
      write_clip(REG_CLIP_Y_MIN, yl);
      write_clip(REG_CLIP_Y_MAX, yh);
      bx_lo = longint'(signed'(xl)); bx_hi = longint'(signed'(xh));
      by_lo = longint'(signed'(yl)); by_hi = longint'(signed'(yh));
   endtask

   // A coordinate around the span lo..hi, reaching half a span beyond each
   // side, clamped to the 32-bit signed range.
   function automatic logic [31:0] near(longint lo, longint hi);
      longint a, b, span, v;
      a    = (lo < hi) ? lo : hi;
      b    = (lo < hi) ? hi : lo;
      span = b - a + 4;
      v    = a - span / 2 + longint'({$urandom, $urandom} % (2 * span + 1));
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   // Random segments: mostly aimed at the current box, with some vertical,
   // horizontal and corner-bound shapes, and a share of raw 32-bit noise.
   task automatic send_random(int count);
      logic [31:0] sx, sy, ex, ey;
      int          shape;
      for (int k = 0; k < count; k++) begin
         sx = near(bx_lo, bx_hi); sy = near(by_lo, by_hi);
         ex = near(bx_lo, bx_hi); ey = near(by_lo, by_hi);
         shape = $urandom_range(0, 9);
         case (shape)
            0: ex = sx;
            1: ey = sy;
            2: begin
               sx = bx_lo[31:0]; sy = by_lo[31:0];
               ex = bx_hi[31:0]; ey = by_hi[31:0];
            end
            3: begin
               sx = $urandom; sy = $urandom; ex = $urandom; ey = $urandom;
            end
            default: ;
         endcase
         send_segment(sx, sy, ex, ey);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed segments against the reset box, which runs from 0.0 to 1.0.
      quiet = 1'b1;
      // Vertical segment spanning the box, upward and downward.
      send_segment(32'h0000_8000, 32'hFFFF_0000, 32'h0000_8000, 32'h0002_0000);
      send_segment(32'h0000_4000, 32'h0002_0000, 32'h0000_4000, 32'hFFFF_0000);
      // Vertical on the left edge: x is not strictly inside, so no points.
      send_segment(32'h0000_0000, 32'hFFFF_0000, 32'h0000_0000, 32'h0002_0000);
      // Vertical that does not span the whole box.
      send_segment(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0002_0000);
      // Horizontal segments across the box in both directions.
      send_segment(32'hFFFF_0000, 32'h0000_8000, 32'h0002_0000, 32'h0000_8000);
      send_segment(32'h0002_0000, 32'h0000_2000, 32'hFFFF_0000, 32'h0000_2000);
      // Horizontal on the top edge gives nothing.
      send_segment(32'hFFFF_0000, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
      // Zero-length segment.
      send_segment(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
      // Diagonal through two corners, forward and backward: duplicate points.
      send_segment(32'hFFFF_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0002_0000);
      send_segment(32'h0002_0000, 32'h0002_0000, 32'hFFFF_0000, 32'hFFFF_0000);
      // Anti-diagonal through the other corners.
      send_segment(32'hFFFF_0000, 32'h0002_0000, 32'h0002_0000, 32'hFFFF_0000);
      // Steep and shallow segments that cross two box sides with truncation.
      send_segment(32'h0000_3333, 32'hFFFF_7777, 32'h0000_9999, 32'h0001_CCCD);
      send_segment(32'hFFFF_5555, 32'h0000_1111, 32'h0001_ABCD, 32'h0000_EEEE);
      // Segment from inside to outside: one point.
      send_segment(32'h0000_8000, 32'h0000_8000, 32'h0003_0001, 32'h0001_7003);
      // Segment wholly inside the box: none.
      send_segment(32'h0000_1000, 32'h0000_2000, 32'h0000_9000, 32'h0000_A000);
      // Extremes of the coordinate range.
      send_segment(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_segment(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      send_segment(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_segment(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
      // Huge quotients: a one-unit run with a near full-range rise saturates.
      send_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFF);
      send_segment(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFE);
      quiet = 1'b0;

      // A moderate box, with random idling on both sides.
      set_box(32'hFFFD_0000, 32'h0005_0000, 32'hFFFE_0000, 32'h0004_0000);
      send_random(30);
      // Long receiver hold while the sender keeps offering items.
      hold_request = 600;
      send_random(30);

      // The widest box there is.
      set_box(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_random(25);

      // An inverted box never keeps a candidate.
      set_box(32'h0004_0000, 32'hFFFC_0000, 32'h0003_0000, 32'hFFFD_0000);
      send_random(15);

      // A tiny box a few raw units wide, run without gaps.
      quiet = 1'b1;
      set_box(32'h0000_0007, 32'h0000_000A, 32'hFFFF_FFF9, 32'hFFFF_FFFC);
      send_random(25);
      quiet = 1'b0;

      // An off-center box near the positive end of the range.
      set_box(32'h7FF0_0000, 32'h7FFF_0000, 32'h1234_5678, 32'h7000_0000);
      send_random(25);

      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog in case the block stops delivering items.
   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
`default_nettype wire

// File: filelist.f
rtl/core/sbcp_pkg.sv
rtl/core/sbcp_csr.sv
rtl/core/sbcp_delay.sv
rtl/core/sbcp_div.sv
rtl/core/sbcp_sort.sv
rtl/core/segment_box_crossing_points_unit.sv
tb/segment_box_crossing_points_checker.sv
tb/segment_box_crossing_points_unit_tb.sv
